[sv/ihex_pkg.sv]
// shared types, character codes and helpers for the hex record parser
`timescale 1ns / 1ps

package ihex_pkg;

    // register map
    localparam int unsigned AddrWidth    = 3;
    localparam int unsigned LimitWidth   = 17;
    localparam logic        REG_LIMIT    = 1'b0;
    localparam logic [16:0] LIMIT_RESET  = 17'd7168;

    // characters and record types of interest
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] TYPE_DATA = 8'h00;
    localparam logic [7:0] TYPE_EOF  = 8'h01;

    // result event codes
    typedef enum logic [2:0] {
        EV_DATA     = 3'd0,
        EV_ACCEPT   = 3'd1,
        EV_DONE     = 3'd2,
        EV_FORMAT   = 3'd3,
        EV_CHECKSUM = 3'd4,
        EV_RANGE    = 3'd5,
        EV_NOEND    = 3'd6
    } ihex_event_t;

    // one input character with its framing flags
    typedef struct packed {
        logic [7:0] ch;
        logic       starts_file;
        logic       ends_file;
    } ihex_in_t;

    // one result item
    typedef struct packed {
        ihex_event_t event_res;
        logic [15:0] byte_address;
        logic [7:0]  byte_value;
    } ihex_out_t;

    // result of one parser step
    typedef struct packed {
        logic      valid;
        ihex_out_t item;
    } ihex_res_t;

    // hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h00;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

[sv/ihex_apb_regs.sv]
// apb register block holding the image limit
`timescale 1ns / 1ps

module ihex_apb_regs
    import ihex_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [AddrWidth-1:0]  paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [LimitWidth-1:0] image_limit
);

    logic [LimitWidth-1:0] limit_reg;
    logic                  reg_sel;

    // word index of the access
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    // register write on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && reg_sel == REG_LIMIT) begin
            limit_reg <= pwdata[LimitWidth-1:0];
        end
    end

    // read back
    always_comb begin
        prdata = 32'h0;
        if (reg_sel == REG_LIMIT) begin
            prdata = {{(32-LimitWidth){1'b0}}, limit_reg};
        end
    end

    assign image_limit = limit_reg;

endmodule

[sv/ihex_parse_core.sv]
// parser state registers and the single-step record decode logic
`timescale 1ns / 1ps

module ihex_parse_core
    import ihex_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  ihex_in_t              item,
    input  logic [LimitWidth-1:0] image_limit,
    output ihex_res_t             res
);

    typedef enum logic [2:0] {
        PH_COLON = 3'd0,
        PH_LEN   = 3'd1,
        PH_ADDR  = 3'd2,
        PH_TYPE  = 3'd3,
        PH_DATA  = 3'd4,
        PH_SUM   = 3'd5,
        PH_TAIL  = 3'd6,
        PH_LF    = 3'd7
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  hold_reg, hold_next;
    logic        half_reg, half_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  seen_reg, seen_next;
    logic        lfault_reg, lfault_next;
    logic        fin_reg, fin_next;

    logic [4:0]  hexv;
    logic [7:0]  b;
    logic [16:0] span;
    logic        do_fail;
    logic        do_finish;
    logic        is_eol;

    assign hexv   = hex_nibble(item.ch);
    assign is_eol = (item.ch == CH_LF) || (item.ch == CH_CR);

    // one character of work
    always_comb begin
        phase_next  = phase_reg;
        hold_next   = hold_reg;
        half_next   = half_reg;
        len_next    = len_reg;
        addr_next   = addr_reg;
        type_next   = type_reg;
        sum_next    = sum_reg;
        seen_next   = seen_reg;
        lfault_next = lfault_reg;
        fin_next    = fin_reg;
        res         = '0;
        do_fail     = 1'b0;
        do_finish   = 1'b0;
        b           = {hold_reg, hexv[3:0]};
        span        = 17'h0;

        // start of a new file clears everything
        if (item.starts_file) begin
            phase_next  = PH_COLON;
            hold_next   = 4'h0;
            half_next   = 1'b0;
            len_next    = 8'h00;
            addr_next   = 16'h0000;
            type_next   = 8'h00;
            sum_next    = 8'h00;
            seen_next   = 8'h00;
            lfault_next = 1'b0;
            fin_next    = 1'b0;
            b           = {4'h0, hexv[3:0]};
        end

        if (!fin_next) begin
            case (phase_next)
                PH_COLON: begin
                    if (item.ch != CH_COLON) begin
                        do_fail = 1'b1;
                    end else begin
                        hold_next   = 4'h0;
                        half_next   = 1'b0;
                        len_next    = 8'h00;
                        addr_next   = 16'h0000;
                        type_next   = 8'h00;
                        sum_next    = 8'h00;
                        seen_next   = 8'h00;
                        lfault_next = 1'b0;
                        phase_next  = PH_LEN;
                    end
                end
                PH_LF: begin
                    if (item.ch != CH_LF) begin
                        do_fail = 1'b1;
                    end else begin
                        do_finish = 1'b1;
                    end
                end
                default: begin
                    if (is_eol) begin
                        // line end before the type byte is a format error
                        if (phase_next == PH_LEN || phase_next == PH_ADDR ||
                            phase_next == PH_TYPE) begin
                            do_fail = 1'b1;
                        end else begin
                            if (phase_next != PH_TAIL) begin
                                lfault_next = 1'b1;
                            end
                            if (item.ch == CH_CR) begin
                                phase_next = PH_LF;
                            end else begin
                                do_finish = 1'b1;
                            end
                        end
                    end else if (!hexv[4]) begin
                        do_fail = 1'b1;
                    end else if (phase_next == PH_TAIL) begin
                        // digits after the checksum
                        lfault_next = 1'b1;
                    end else if (!half_next) begin
                        hold_next = hexv[3:0];
                        half_next = 1'b1;
                    end else begin
                        // second digit completes a byte
                        half_next = 1'b0;
                        sum_next  = 8'(sum_next + b);
                        case (phase_next)
                            PH_LEN: begin
                                len_next   = b;
                                seen_next  = 8'h00;
                                phase_next = PH_ADDR;
                            end
                            PH_ADDR: begin
                                addr_next = {addr_next[7:0], b};
                                seen_next = 8'(seen_next + 8'd1);
                                if (seen_next >= 8'd2) begin
                                    phase_next = PH_TYPE;
                                end
                            end
                            PH_TYPE: begin
                                type_next  = b;
                                seen_next  = 8'h00;
                                phase_next = (len_next == 8'h00) ? PH_SUM : PH_DATA;
                            end
                            PH_DATA: begin
                                if (type_next == TYPE_DATA) begin
                                    res.valid             = 1'b1;
                                    res.item.event_res    = EV_DATA;
                                    res.item.byte_address =
                                        16'(addr_next + {8'h00, seen_next});
                                    res.item.byte_value   = b;
                                end
                                seen_next = 8'(seen_next + 8'd1);
                                if (seen_next == len_next) begin
                                    phase_next = PH_SUM;
                                end
                            end
                            default: begin
                                phase_next = PH_TAIL;
                            end
                        endcase
                    end
                end
            endcase

            // format error halts the parser
            if (do_fail) begin
                fin_next              = 1'b1;
                res.valid             = 1'b1;
                res.item.event_res    = EV_FORMAT;
                res.item.byte_address = addr_next;
                res.item.byte_value   = 8'h00;
            end

            // line end verdict
            if (do_finish) begin
                phase_next = PH_COLON;
                span       = {1'b0, addr_next} + {9'h000, len_next};
                if (type_next == TYPE_DATA) begin
                    res.valid             = 1'b1;
                    res.item.byte_address = addr_next;
                    res.item.byte_value   = 8'h00;
                    if (lfault_next) begin
                        res.item.event_res = EV_FORMAT;
                    end else if (sum_next != 8'h00) begin
                        res.item.event_res = EV_CHECKSUM;
                    end else if (span > image_limit) begin
                        res.item.event_res = EV_RANGE;
                    end else begin
                        res.item.event_res = EV_ACCEPT;
                    end
                    if (res.item.event_res != EV_ACCEPT) begin
                        fin_next = 1'b1;
                    end
                end else if (type_next == TYPE_EOF) begin
                    fin_next              = 1'b1;
                    res.valid             = 1'b1;
                    res.item.event_res    = EV_DONE;
                    res.item.byte_address = addr_next;
                    res.item.byte_value   = 8'h00;
                end
            end

            // last character without an end record
            if (item.ends_file && !fin_next) begin
                fin_next              = 1'b1;
                res.valid             = 1'b1;
                res.item.event_res    = EV_NOEND;
                res.item.byte_address = addr_next;
                res.item.byte_value   = 8'h00;
            end
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_COLON;
            hold_reg   <= 4'h0;
            half_reg   <= 1'b0;
            len_reg    <= 8'h00;
            addr_reg   <= 16'h0000;
            type_reg   <= 8'h00;
            sum_reg    <= 8'h00;
            seen_reg   <= 8'h00;
            lfault_reg <= 1'b0;
            fin_reg    <= 1'b0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            hold_reg   <= hold_next;
            half_reg   <= half_next;
            len_reg    <= len_next;
            addr_reg   <= addr_next;
            type_reg   <= type_next;
            sum_reg    <= sum_next;
            seen_reg   <= seen_next;
            lfault_reg <= lfault_next;
            fin_reg    <= fin_next;
        end
    end

endmodule

[sv/intel_hex_record_parser_unit.sv]
// top level: input register, parser core, result register and apb port
`timescale 1ns / 1ps

// Intel HEX record parser.
// The s_ channel takes one character per request together with its
// starts_file and ends_file flags; the m_ channel returns at most one result
// per character: a data byte with its image address, or a status event.
// Both channels use valid/ready. A character is held in an input register,
// decoded combinationally by the parser core and its result lands in an
// output register. Throughput is one character per cycle while the receiver
// keeps taking results. When the receiver stalls with a result pending, the
// next character stays in the input register and s_ready drops once that
// register is full too. Characters that produce no result still wait for
// the output register. The image limit is written through the apb port; the
// user must do so only while the block is idle, which the block does not
// enforce. Reset (aresetn low, synchronous) empties both registers, returns
// the parser to waiting for a colon and loads the image limit with 7168.

module intel_hex_record_parser_unit
    import ihex_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ihex_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ihex_out_t            m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic                  in_valid_reg;
    ihex_in_t              in_data_reg;
    logic                  out_valid_reg;
    ihex_out_t             out_data_reg;
    logic                  out_free;
    logic                  step_en;
    ihex_res_t             res;
    logic [LimitWidth-1:0] image_limit;

    ihex_apb_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .image_limit (image_limit)
    );

    ihex_parse_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .item        (in_data_reg),
        .image_limit (image_limit),
        .res         (res)
    );

    // flow control between the two registers
    assign out_free = !out_valid_reg || m_ready;
    assign step_en  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || step_en;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step_en) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= res.valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && res.valid) begin
            out_data_reg <= res.item;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // a stalled input side only ever means a full input register
    a_ready_low_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg)
        else $error("s_ready low with empty input register");

    // a produced result shows up on the output next cycle
    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.valid |=> m_valid)
        else $error("parser result lost");

    // status events carry a zero byte value
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_res != EV_DATA |-> m_data.byte_value == 8'h00)
        else $error("status event with nonzero byte value");

    // no step while a stalled result is held
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !step_en)
        else $error("pending result overwritten");

endmodule
